// ----- rtl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and helpers for the matrix-to-quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Width of a component numerator magnitude (sum or difference of two Q values)
    localparam int MAG_W     = 17;
    // Quotient bits resolved by the divider cells
    localparam int DIV_STEPS = 17;
    // Width of one matrix element or quaternion component
    localparam int VAL_W     = 16;

    // Lead component positions
    localparam logic [1:0] POS_W = 2'd0;
    localparam logic [1:0] POS_X = 2'd1;
    localparam logic [1:0] POS_Y = 2'd2;
    localparam logic [1:0] POS_Z = 2'd3;

    // Side information that travels with a beat through the cells
    typedef struct packed {
        logic [1:0]             lead;
        logic                   degen;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
    } t_tag;

    // Saturate a signed quotient given as sign, overflow and magnitude
    function automatic logic [VAL_W-1:0] sat_comp(input logic neg, input logic ovf,
                                                  input logic [DIV_STEPS-1:0] q);
        logic [DIV_STEPS-1:0] q_n;
        q_n = -q;
        if (!neg) begin
            sat_comp = (ovf || q > 17'd32767) ? 16'h7fff : q[VAL_W-1:0];
        end else begin
            sat_comp = (ovf || q > 17'd32768) ? 16'h8000 : q_n[VAL_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a Q-format 3x3 rotation matrix to a quaternion (Shoemake).
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_..tready    tdata: 9 matrix elements
//  m_axis    out  o_m_axis_tvalid/i_..tready    tdata: w x y z, tuser: degenerate
//
// One matrix per cycle is taken while the output is not stalled. A beat runs
// through the square-root cell row (one root bit per cell, RW = half the radicand
// width) and the divider cell row (17 quotient bits).
// Reset clears all valid flags; no clearing pass is needed.
// A stalled output holds the whole row and the input; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each from bit 0
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // quat_w quat_x quat_y quat_z, 16 bits each from bit 0
    output logic [63:0]  o_m_axis_tdata,
    // degenerate
    output logic         o_m_axis_tuser
);

    localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NW = ((AW - 1 + FRAC_BITS + 1) / 2) * 2;
    localparam int RW = NW / 2;
    localparam int WW = ((FRAC_BITS > RW) ? FRAC_BITS : RW) + 18;
    localparam int DS = rmq_pkg::DIV_STEPS;
    localparam int MW = rmq_pkg::MAG_W;
    localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

    logic en;
    logic r_out_valid;

    // Advance the whole row unless a finished beat is stuck at the output
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---------------- front stage: case select, argument, numerators
    logic signed [15:0] m [9];
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            m[e] = i_s_axis_tdata[e*16 +: 16];
        end
    end

    logic signed [AW-1:0]  trace;
    logic signed [AW-1:0]  arg;
    logic signed [MW-1:0]  d [3];
    logic [1:0]            lead;
    rmq_pkg::t_tag         f_tag;
    logic [NW-1:0]         f_rad;

    always_comb begin
        trace = AW'(m[0]) + AW'(m[4]) + AW'(m[8]);
        lead  = rmq_pkg::POS_W;
        if (trace > 0) begin
            arg  = trace + ONE;
            d[0] = MW'(m[7]) - MW'(m[5]);
            d[1] = MW'(m[2]) - MW'(m[6]);
            d[2] = MW'(m[3]) - MW'(m[1]);
        end else if (m[8] > ((m[4] > m[0]) ? m[4] : m[0])) begin
            lead = rmq_pkg::POS_Z;
            arg  = AW'(m[8]) - AW'(m[0]) - AW'(m[4]) + ONE;
            d[0] = MW'(m[3]) - MW'(m[1]);
            d[1] = MW'(m[2]) + MW'(m[6]);
            d[2] = MW'(m[5]) + MW'(m[7]);
        end else if (m[4] > m[0]) begin
            lead = rmq_pkg::POS_Y;
            arg  = AW'(m[4]) - AW'(m[8]) - AW'(m[0]) + ONE;
            d[0] = MW'(m[2]) - MW'(m[6]);
            d[1] = MW'(m[1]) + MW'(m[3]);
            d[2] = MW'(m[7]) + MW'(m[5]);
        end else begin
            lead = rmq_pkg::POS_X;
            arg  = AW'(m[0]) - AW'(m[4]) - AW'(m[8]) + ONE;
            d[0] = MW'(m[7]) - MW'(m[5]);
            d[1] = MW'(m[3]) + MW'(m[1]);
            d[2] = MW'(m[6]) + MW'(m[2]);
        end
        f_tag.lead  = lead;
        f_tag.degen = (arg <= 0);
        for (int l = 0; l < 3; l++) begin
            f_tag.neg[l] = d[l][MW-1];
            f_tag.mag[l] = d[l][MW-1] ? MW'(-d[l]) : MW'(d[l]);
        end
        f_rad = NW'({arg[AW-2:0], {FRAC_BITS{1'b0}}});
    end

    logic           r_f_valid;
    rmq_pkg::t_tag  r_f_tag;
    logic [NW-1:0]  r_f_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_tag <= f_tag;
            r_f_rad <= f_rad;
        end
    end

    // ---------------- square-root cell row
    logic                sq_valid [RW+1];
    rmq_pkg::t_tag       sq_tag   [RW+1];
    logic [NW-1:0]       sq_rad   [RW+1];
    logic [RW+1:0]       sq_rem   [RW+1];
    logic [RW-1:0]       sq_root  [RW+1];

    assign sq_valid[0] = r_f_valid;
    assign sq_tag[0]   = r_f_tag;
    assign sq_rad[0]   = r_f_rad;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;

    for (genvar c = 0; c < RW; c++) begin : g_sqrt
        rmq_sqrt_cell #(.NW(NW), .RW(RW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[c]),
            .i_tag   (sq_tag[c]),
            .i_rad   (sq_rad[c]),
            .i_rem   (sq_rem[c]),
            .i_root  (sq_root[c]),
            .o_valid (sq_valid[c+1]),
            .o_tag   (sq_tag[c+1]),
            .o_rad   (sq_rad[c+1]),
            .o_rem   (sq_rem[c+1]),
            .o_root  (sq_root[c+1])
        );
    end

    // ---------------- divider set-up stage
    logic [RW-1:0]      s_root;
    logic [WW-1:0]      den_w;
    logic [2:0][WW-1:0] num_w;
    logic [2:0]         ovf_w;
    rmq_pkg::t_tag      p_tag;

    always_comb begin
        s_root      = sq_root[RW];
        den_w       = WW'({s_root, 1'b0});
        p_tag       = sq_tag[RW];
        p_tag.degen = sq_tag[RW].degen || (s_root == '0);
        for (int l = 0; l < 3; l++) begin
            num_w[l] = (WW'(sq_tag[RW].mag[l]) << FRAC_BITS) + WW'(s_root);
            ovf_w[l] = (num_w[l] >= (den_w << DS));
        end
    end

    logic                   dv_valid [DS+1];
    rmq_pkg::t_tag          dv_tag   [DS+1];
    logic [RW-1:0]          dv_root  [DS+1];
    logic [WW-1:0]          dv_den   [DS+1];
    logic [2:0][WW-1:0]     dv_rem   [DS+1];
    logic [2:0][DS-1:0]     dv_quo   [DS+1];
    logic [2:0]             dv_ovf   [DS+1];

    logic                   r_p_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= sq_valid[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_tag[0]  <= p_tag;
            dv_root[0] <= s_root;
            dv_den[0]  <= den_w << (DS - 1);
            dv_rem[0]  <= num_w;
            dv_ovf[0]  <= ovf_w;
        end
    end

    assign dv_valid[0] = r_p_valid;
    assign dv_quo[0]   = '0;

    // ---------------- divider cell row
    for (genvar c = 0; c < DS; c++) begin : g_div
        rmq_div_cell #(.WW(WW), .RW(RW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[c]),
            .i_tag   (dv_tag[c]),
            .i_root  (dv_root[c]),
            .i_den   (dv_den[c]),
            .i_rem   (dv_rem[c]),
            .i_quo   (dv_quo[c]),
            .i_ovf   (dv_ovf[c]),
            .o_valid (dv_valid[c+1]),
            .o_tag   (dv_tag[c+1]),
            .o_root  (dv_root[c+1]),
            .o_den   (dv_den[c+1]),
            .o_rem   (dv_rem[c+1]),
            .o_quo   (dv_quo[c+1]),
            .o_ovf   (dv_ovf[c+1])
        );
    end

    // ---------------- result assembly
    logic [RW-2:0]      half_root;
    logic [15:0]        lead_v;
    logic [2:0][15:0]   lane_v;
    logic [3:0][15:0]   comp;
    logic [63:0]        n_out_data;
    rmq_pkg::t_tag      e_tag;

    always_comb begin
        e_tag     = dv_tag[DS];
        half_root = dv_root[DS][RW-1:1];
        lead_v    = (half_root > 32767) ? 16'h7fff : 16'(half_root);
        for (int l = 0; l < 3; l++) begin
            lane_v[l] = rmq_pkg::sat_comp(e_tag.neg[l], dv_ovf[DS][l], dv_quo[DS][l]);
        end
        // Lead sits at its place, lanes fill the others in order
        for (int p = 0; p < 4; p++) begin
            if (2'(p) == e_tag.lead) begin
                comp[p] = lead_v;
            end else if (2'(p) < e_tag.lead) begin
                comp[p] = lane_v[p];
            end else begin
                comp[p] = lane_v[p-1];
            end
        end
        n_out_data = e_tag.degen ? '0 : comp;
    end

    logic [63:0] r_out_data;
    logic        r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data  <= n_out_data;
            r_out_degen <= e_tag.degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_degen;

    // ---------------- checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate beat carries non-zero components");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_valid && !en) |=> ($stable(r_f_rad) && r_f_valid))
        else $error("front stage moved while stalled");

endmodule

// ----- rtl/rmq_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One step of the restoring square root: settles one root bit per beat.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int NW = 40,
    parameter int RW = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  rmq_pkg::t_tag       i_tag,
    input  logic [NW-1:0]       i_rad,
    input  logic [RW+1:0]       i_rem,
    input  logic [RW-1:0]       i_root,
    output logic                o_valid,
    output rmq_pkg::t_tag       o_tag,
    output logic [NW-1:0]       o_rad,
    output logic [RW+1:0]       o_rem,
    output logic [RW-1:0]       o_root
);

    logic [RW+3:0] rem_t;
    logic [RW+3:0] trial;
    logic          take;
    logic [RW+3:0] rem_d;

    // Bring down two radicand bits and try the next root bit
    assign rem_t = {i_rem, i_rad[NW-1:NW-2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign take  = (rem_t >= trial);
    assign rem_d = take ? (rem_t - trial) : rem_t;

    // Clear valid under reset, advance payload on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag  <= i_tag;
            o_rad  <= {i_rad[NW-3:0], 2'b00};
            o_rem  <= rem_d[RW+1:0];
            o_root <= {i_root[RW-2:0], take};
        end
    end

endmodule

// ----- rtl/rmq_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step for three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int WW = 60,
    parameter int RW = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  rmq_pkg::t_tag                       i_tag,
    input  logic [RW-1:0]                       i_root,
    input  logic [WW-1:0]                       i_den,
    input  logic [2:0][WW-1:0]                  i_rem,
    input  logic [2:0][rmq_pkg::DIV_STEPS-1:0]  i_quo,
    input  logic [2:0]                          i_ovf,
    output logic                                o_valid,
    output rmq_pkg::t_tag                       o_tag,
    output logic [RW-1:0]                       o_root,
    output logic [WW-1:0]                       o_den,
    output logic [2:0][WW-1:0]                  o_rem,
    output logic [2:0][rmq_pkg::DIV_STEPS-1:0]  o_quo,
    output logic [2:0]                          o_ovf
);

    logic [2:0]           take;
    logic [2:0][WW-1:0]   rem_d;

    // Compare each lane with the shifted divisor
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            take[l]  = (i_rem[l] >= i_den);
            rem_d[l] = take[l] ? (i_rem[l] - i_den) : i_rem[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag  <= i_tag;
            o_root <= i_root;
            o_den  <= i_den >> 1;
            o_ovf  <= i_ovf;
            for (int l = 0; l < 3; l++) begin
                o_rem[l] <= rem_d[l];
                o_quo[l] <= {i_quo[l][rmq_pkg::DIV_STEPS-2:0], take[l]};
            end
        end
    end

endmodule
